@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL; they expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds at an edge, so cons holds at the same edge
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante holds at an edge, so cons holds at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// expr never holds at an edge
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

@@ src/ffd_pkg.sv @@
package ffd_pkg;

	// field widths
	localparam int TS_W    = 32;
	localparam int ACC_W   = 16;
	localparam int CFG_W   = 12;
	localparam int DUR_W   = 16;
	localparam int DIST_W  = 25;

	// stream payload widths
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - DUR_W - DIST_W;

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_REST_LEVEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_TOL   = 1'b1;
	localparam logic [CFG_W-1:0] RST_REST_LEVEL = 12'd1000;
	localparam logic [CFG_W-1:0] RST_BAND_TOL   = 12'd300;

	// band check arithmetic
	localparam int HI_W    = CFG_W + 1;
	localparam int HI_SQ_W = 2 * HI_W;
	localparam int LO_SQ_W = 2 * CFG_W;
	localparam int M2_W    = 32;

	// event kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_END   = 1'b1;

	// duration and distance
	localparam int MAX_FALL_MS = 65535;
	localparam int DIST_MUL    = 49;
	localparam int DIST_DIV    = 10000;
	localparam int PROD_W      = 2 * DUR_W;
	localparam int NUM_W       = PROD_W + 6;

	// divide by 10000: drop four bits (/16), then multiply by a reciprocal of 625
	localparam int DIV_POW2_W = 4;
	localparam int T_W        = NUM_W - DIV_POW2_W;
	localparam int T_HALF_W   = T_W / 2;
	localparam int RCP_W      = 32;
	localparam logic [RCP_W-1:0] RCP_625 = 32'd3518437209;  // ceil(2^41 / 625)
	localparam int PP_W       = T_HALF_W + RCP_W;
	localparam int Q_LSB      = PP_W - DIST_W;  // with T_HALF_W, a 41-bit shift

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one classified sample
	typedef struct packed {
		logic [TS_W-1:0] ts;
		logic            rest;
	} item_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// one result item
	typedef struct packed {
		logic              kind;
		logic [DUR_W-1:0]  dur;
		logic [DIST_W-1:0] dist_mm;
	} result_t;

endpackage

@@ src/ffd_queue.sv @@
module ffd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ffd_pkg::item_t push_item,
	input  logic           pop,
	output ffd_pkg::item_t pop_item,
	output ffd_pkg::qstat_t qstat
);
	import ffd_pkg::*;

	item_t               entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	// status and head entry
	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_item    = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ src/ffd_front.sv @@
module ffd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ffd_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                              cfg_we,
	input  logic [ffd_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [ffd_pkg::CFG_W-1:0]         cfg_wdata,
	input  ffd_pkg::qstat_t                   qstat,
	output logic                              push,
	output ffd_pkg::item_t                    push_item
);
	import ffd_pkg::*;

	localparam logic [1:0] STEP_X   = 2'd0;
	localparam logic [1:0] STEP_Y   = 2'd1;
	localparam logic [1:0] STEP_Z   = 2'd2;
	localparam logic [1:0] STEP_CMP = 2'd3;

	logic [CFG_W-1:0]    rest_q;
	logic [CFG_W-1:0]    tol_q;
	logic [HI_W-1:0]     hi;
	logic [CFG_W-1:0]    lo;
	logic [HI_SQ_W-1:0]  hi_sq_q;
	logic [LO_SQ_W-1:0]  lo_sq_q;
	logic                lo_en_q;

	logic                busy_q;
	logic [1:0]          step_q;
	logic [TS_W-1:0]     ts_q;
	logic signed [ACC_W-1:0] ax_q, ay_q, az_q;
	logic signed [ACC_W-1:0] axis;
	logic signed [M2_W-1:0]  sq_s;
	logic [M2_W-1:0]     acc_q;
	logic                rest;
	logic                accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= RST_REST_LEVEL;
			tol_q  <= RST_BAND_TOL;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_REST_LEVEL: rest_q <= cfg_wdata;
				REG_BAND_TOL:   tol_q  <= cfg_wdata;
			endcase
		end
	end

	// squared band bounds, refreshed every cycle
	assign hi = {1'b0, rest_q} + {1'b0, tol_q};
	assign lo = rest_q - tol_q;

	always_ff @(posedge clk) begin
		hi_sq_q <= hi * hi;
		lo_sq_q <= lo * lo;
		lo_en_q <= (rest_q > tol_q);
	end

	// shared squarer, one axis per step
	always_comb begin
		unique case (step_q)
			STEP_X:   axis = ax_q;
			STEP_Y:   axis = ay_q;
			STEP_Z:   axis = az_q;
			STEP_CMP: axis = '0;
		endcase
	end

	assign sq_s = axis * axis;

	// band check on the finished sum
	assign rest = (acc_q <= {{(M2_W-HI_SQ_W){1'b0}}, hi_sq_q}) &&
		(!lo_en_q || (acc_q >= {{(M2_W-LO_SQ_W){1'b0}}, lo_sq_q}));

	assign push           = busy_q && (step_q == STEP_CMP) && !qstat.full;
	assign push_item.ts   = ts_q;
	assign push_item.rest = rest;
	assign s_tready       = !busy_q || push;
	assign accept         = s_tvalid && s_tready;

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_X;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= STEP_X;
		end else if (push) begin
			busy_q <= 1'b0;
		end else if (busy_q && (step_q != STEP_CMP)) begin
			step_q <= step_q + 1'b1;
		end
	end

	// sample and accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			ts_q  <= s_tdata[TS_W-1:0];
			ax_q  <= s_tdata[TS_W +: ACC_W];
			ay_q  <= s_tdata[TS_W+ACC_W +: ACC_W];
			az_q  <= s_tdata[TS_W+2*ACC_W +: ACC_W];
			acc_q <= '0;
		end else if (busy_q && (step_q != STEP_CMP)) begin
			acc_q <= acc_q + $unsigned(sq_s);
		end
	end

endmodule

@@ src/ffd_back.sv @@
module ffd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ffd_pkg::qstat_t  qstat,
	input  ffd_pkg::item_t   pop_item,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output ffd_pkg::result_t res
);
	import ffd_pkg::*;

	localparam logic [2:0] B_IDLE   = 3'd0;
	localparam logic [2:0] B_MUL    = 3'd1;
	localparam logic [2:0] B_SCALE  = 3'd2;
	localparam logic [2:0] B_RCP_LO = 3'd3;
	localparam logic [2:0] B_RCP_HI = 3'd4;
	localparam logic [2:0] B_WAIT   = 3'd5;

	logic [2:0]           state_q;
	logic                 falling_q;
	logic [TS_W-1:0]      start_q;
	logic [DUR_W-1:0]     d_q;
	logic [PROD_W-1:0]    prod_q;
	logic [NUM_W-1:0]     scaled;
	logic [T_W-1:0]       t_q;
	logic [T_HALF_W-1:0]  t_half;
	logic [PP_W-1:0]      pp;
	logic [PP_W-1:0]      pp_q;
	logic [TS_W-1:0]      diff;
	logic [DUR_W-1:0]     d_sat;
	logic                 out_free;
	logic                 start_evt;
	logic                 end_evt;
	logic                 load_start;
	logic                 load_end;

	// item classification against fall state
	assign out_free  = !m_tvalid || m_tready;
	assign pop       = (state_q == B_IDLE) && !qstat.empty && out_free;
	assign start_evt = pop && !falling_q && !pop_item.rest;
	assign end_evt   = pop && falling_q && pop_item.rest;
	assign load_start = start_evt;
	assign load_end   = (state_q == B_WAIT) && out_free;

	// duration, modulo difference saturated
	assign diff  = pop_item.ts - start_q;
	assign d_sat = (diff > TS_W'(MAX_FALL_MS)) ? DUR_W'(MAX_FALL_MS) : diff[DUR_W-1:0];

	assign scaled  = {{(NUM_W-PROD_W){1'b0}}, prod_q} * NUM_W'(DIST_MUL);

	// one 17x32 reciprocal multiplier, low half of t first, then high half
	assign t_half = (state_q == B_RCP_HI) ? t_q[T_W-1:T_HALF_W] : t_q[T_HALF_W-1:0];
	assign pp     = {{(PP_W-T_HALF_W){1'b0}}, t_half} * {{(PP_W-RCP_W){1'b0}}, RCP_625};

	// sequencer and fall state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			falling_q <= 1'b0;
			start_q   <= '0;
			m_tvalid  <= 1'b0;
		end else begin
			if (load_start || load_end)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;

			unique case (state_q)
				B_IDLE: begin
					if (start_evt) begin
						falling_q <= 1'b1;
						start_q   <= pop_item.ts;
					end else if (end_evt) begin
						falling_q <= 1'b0;
						state_q   <= B_MUL;
					end
				end
				B_MUL:    state_q <= B_SCALE;
				B_SCALE:  state_q <= B_RCP_LO;
				B_RCP_LO: state_q <= B_RCP_HI;
				B_RCP_HI: state_q <= B_WAIT;
				B_WAIT: begin
					if (out_free)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath: square, scale and drop four bits, reciprocal multiply in two halves
	always_ff @(posedge clk) begin
		if (end_evt)
			d_q <= d_sat;
		if (state_q == B_MUL)
			prod_q <= {{DUR_W{1'b0}}, d_q} * {{DUR_W{1'b0}}, d_q};
		if (state_q == B_SCALE)
			t_q <= scaled[NUM_W-1:DIV_POW2_W];
		if (state_q == B_RCP_LO)
			pp_q <= pp;
		else if (state_q == B_RCP_HI)
			pp_q <= pp + (pp_q >> T_HALF_W);
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_start) begin
			res.kind    <= KIND_START;
			res.dur     <= '0;
			res.dist_mm <= '0;
		end else if (load_end) begin
			res.kind    <= KIND_END;
			res.dur     <= d_q;
			res.dist_mm <= pp_q[PP_W-1:Q_LSB];
		end
	end

endmodule

@@ src/free_fall_detector.sv @@
// Channel  | Dir | Handshake          | Payload
// s        | in  | s_tvalid/s_tready  | s_tdata: timestamp_ms, accel_x, accel_y, accel_z
// m        | out | m_tvalid/m_tready  | m_tdata: fall_duration_ms, fall_distance_mm
//          |     |                    | m_tuser: event_kind
// cfg      | in  | cfg_we             | cfg_idx, cfg_wdata
//
// Front takes one sample at a time: accept, then x, y, z squared one per cycle on
// a single 16x16 multiplier; the band compare overlaps the next accept.
// Back drains one queued item per cycle while the output register is free and no fall
// end is in progress; a fall end runs through duration, square, scale by 49 and drop four
// bits, two 17x32 reciprocal steps dividing by 625, and result.
// Reset sets rest_level 1000 and band_tolerance 300 and clears the fall state.
// A two-entry queue and the output register let front and back stall independently.
`include "assert_macros.svh"

module free_fall_detector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] timestamp_ms, [47:32] accel_x, [63:48] accel_y, [79:64] accel_z
	input  logic [ffd_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] fall_duration_ms, [40:16] fall_distance_mm, [47:41] zero
	output logic [ffd_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// [0] event_kind
	output logic                               m_tuser,
	input  logic                               cfg_we,
	input  logic [ffd_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [ffd_pkg::CFG_W-1:0]          cfg_wdata
);
	import ffd_pkg::*;

	qstat_t  qstat;
	item_t   push_item;
	item_t   pop_item;
	logic    push;
	logic    pop;
	result_t res;

	ffd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	ffd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	ffd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_item (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	// output packing
	assign m_tdata = {{OUT_PAD_W{1'b0}}, res.dist_mm, res.dur};
	assign m_tuser = res.kind;

	// checks
	`ASSERT_NEVER(a_push_full, push && qstat.full, "push into full queue")
	`ASSERT_NEVER(a_pop_empty, pop && qstat.empty, "pop from empty queue")
	`ASSERT_IMPLY(a_start_zero, m_tvalid && (m_tuser == KIND_START), m_tdata == '0, "start data")
	`ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "front ready too early")

endmodule
